// ===== hw/rtl/mac_address_frequency_table_top_macros.svh =====
// Assertion macros shared by the MAC address frequency table RTL.
// Included by the top level; depends on nothing else.
`ifndef MAC_ADDRESS_FREQUENCY_TABLE_TOP_MACROS_SVH
`define MAC_ADDRESS_FREQUENCY_TABLE_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MFT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mft assertion failed");

// Antecedent implies consequent in the next cycle.
`define MFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mft assertion failed");

`endif

// ===== hw/rtl/mft_pkg.sv =====
// Package for the MAC address frequency table: sizes, codes, types and
// count helpers. Used by every module of the block; depends on nothing.
package mft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_WIDTH = 32;

  localparam int MAC_W      = 48;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_CNT_W  = 32;
  localparam int OUT_FILL_W = 7;

  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W    = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W     = IDX_W + OUT_IDX_W;
  localparam int CNT_EXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  // Operation codes of a request.
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // One table entry as it travels around the ring of cells.
  typedef struct packed {
    logic [MAC_W-1:0]       mac;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  // Result fields built up during a scan.
  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic [MAC_W-1:0]     mac;
    logic [OUT_CNT_W-1:0] count;
    logic                 was_new;
    logic                 full;
    logic                 valid;
  } result_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic              busy;
    logic [FILL_W-1:0] fill;
  } status_t;

  // Count plus one, holding at the all-ones value.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH-1:0] r;
    r = (c == {COUNT_WIDTH{1'b1}}) ? c : COUNT_WIDTH'(c + 1'b1);
    return r;
  endfunction

  // Count as reported on the result port, clamped to the port width.
  function automatic logic [OUT_CNT_W-1:0] out_count(input logic [COUNT_WIDTH-1:0] c);
    logic [CNT_EXT_W-1:0] e;
    logic [OUT_CNT_W-1:0] r;
    e = CNT_EXT_W'(c);
    if (e > CNT_EXT_W'({OUT_CNT_W{1'b1}})) begin
      r = {OUT_CNT_W{1'b1}};
    end else begin
      r = e[OUT_CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mft_cell.sv =====
// One storage cell of the entry ring: holds an address and its count.
// Depends on mft_pkg for the entry type.
module mft_cell (
  input  logic            clk,
  input  logic            shift,
  input  mft_pkg::entry_t din,
  output mft_pkg::entry_t q
);
  import mft_pkg::*;

  // Take the neighbor's entry whenever the ring rotates.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

// ===== hw/rtl/mft_seq.sv =====
// Scan sequencer of the MAC address frequency table: compares, updates,
// inserts and reads entries as they pass the ring head. Depends on mft_pkg.
module mft_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            operation,
  input  logic [mft_pkg::MAC_W-1:0]       mac_address,
  input  logic [mft_pkg::OUT_IDX_W-1:0]   read_index,
  input  mft_pkg::entry_t                 head,
  output mft_pkg::entry_t                 tail,
  output logic                            shift,
  output mft_pkg::result_t                result,
  output logic [mft_pkg::OUT_FILL_W-1:0]  used,
  output logic                            strobe,
  output mft_pkg::status_t                status
);
  import mft_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  logic [IDX_W-1:0]     step;
  logic [FILL_W-1:0]    fill;
  logic                 op_q;
  logic [MAC_W-1:0]     mac_q;
  logic [OUT_IDX_W-1:0] ridx_q;
  logic                 hit_q;
  logic                 ins_q;
  result_t              res_q;

  logic                   scan;
  logic                   step_valid;
  logic                   last_step;
  logic                   is_hit;
  logic                   is_ins;
  logic                   is_rd;
  logic [COUNT_WIDTH-1:0] hit_count;

  // Head-of-ring decisions for the entry whose index equals step.
  always_comb begin
    scan       = (state == ST_SCAN);
    step_valid = (FILL_W'(step) < fill);
    last_step  = (step == IDX_W'(TABLE_DEPTH - 1));
    hit_count  = sat_inc(head.count);
    is_hit     = scan && (op_q == OP_COUNT) && step_valid && (head.mac == mac_q);
    is_ins     = scan && (op_q == OP_COUNT) && !hit_q && (FILL_W'(step) == fill);
    is_rd      = scan && (op_q == OP_READ) && step_valid &&
                 (CMP_W'(step) == CMP_W'(ridx_q));
  end

  // Entry handed back into the tail of the ring.
  always_comb begin
    tail = head;
    if (is_hit) begin
      tail.count = hit_count;
    end else if (is_ins) begin
      tail.mac   = mac_q;
      tail.count = COUNT_WIDTH'(1);
    end
  end

  assign shift         = scan;
  assign result        = res_q;
  assign used          = OUT_FILL_W'(fill);
  assign status.busy   = scan;
  assign status.fill   = fill;

  // Request capture, one pass over the ring, then the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_q          <= operation;
            mac_q         <= mac_address;
            ridx_q        <= read_index;
            step          <= '0;
            hit_q         <= 1'b0;
            ins_q         <= 1'b0;
            res_q.was_new <= 1'b0;
            res_q.valid   <= 1'b0;
            res_q.count   <= '0;
            if (operation == OP_READ) begin
              res_q.index <= read_index;
              res_q.mac   <= '0;
              res_q.full  <= 1'b0;
            end else begin
              res_q.index <= '0;
              res_q.mac   <= mac_address;
              res_q.full  <= (fill == FILL_W'(TABLE_DEPTH));
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          step <= IDX_W'(step + 1'b1);
          if (is_hit) begin
            hit_q       <= 1'b1;
            res_q.index <= OUT_IDX_W'(step);
            res_q.count <= out_count(hit_count);
            res_q.valid <= 1'b1;
            res_q.full  <= 1'b0;
          end
          if (is_ins) begin
            ins_q         <= 1'b1;
            res_q.index   <= OUT_IDX_W'(step);
            res_q.count   <= OUT_CNT_W'(1);
            res_q.was_new <= 1'b1;
            res_q.valid   <= 1'b1;
          end
          if (is_rd) begin
            res_q.mac   <= head.mac;
            res_q.count <= out_count(head.count);
            res_q.valid <= 1'b1;
          end
          if (last_step) begin
            state  <= ST_IDLE;
            strobe <= 1'b1;
            if (is_ins || ins_q) begin
              fill <= FILL_W'(fill + 1'b1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mac_address_frequency_table_top.sv =====
// Top level of the MAC address frequency table: a ring of entry cells and
// its scan sequencer. Depends on mft_pkg, mft_cell, mft_seq and the macros.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   operation selects counting of mac_address or reading of entry read_index.
//   Every request gives exactly one result, shown on the entry_* ports,
//   was_new, table_full and entries_used for one cycle with result_strobe
//   high; the receiver has no way to stall it and must take it then.
//   The entries sit in a ring of TABLE_DEPTH cells that rotates one place a
//   cycle while a request is scanned; the sequencer compares and updates the
//   entry at the ring head. A request makes one full turn of the ring and its
//   result is registered as the turn ends.
//   busy falls as the strobe rises, so a new request can be taken in the
//   strobe cycle; no new request is taken while one is being scanned.
//   Reset empties the table by clearing the fill level; entry contents are
//   left as they are and no clearing pass is needed, since only filled
//   entries are ever compared or read.
module mac_address_frequency_table_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation,
  input  logic [mft_pkg::MAC_W-1:0]        mac_address,
  input  logic [mft_pkg::OUT_IDX_W-1:0]    read_index,
  output logic                             result_strobe,
  output logic [mft_pkg::OUT_IDX_W-1:0]    entry_index,
  output logic [mft_pkg::MAC_W-1:0]        entry_mac,
  output logic [mft_pkg::OUT_CNT_W-1:0]    entry_count,
  output logic                             was_new,
  output logic                             table_full,
  output logic                             entry_valid,
  output logic [mft_pkg::OUT_FILL_W-1:0]   entries_used
);
  import mft_pkg::*;

  `include "mac_address_frequency_table_top_macros.svh"

  entry_t  ring [TABLE_DEPTH];
  entry_t  tail;
  logic    shift;
  result_t result;
  status_t status;

  // Sequencer working at the head of the ring.
  mft_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .mac_address (mac_address),
    .read_index  (read_index),
    .head        (ring[0]),
    .tail        (tail),
    .shift       (shift),
    .result      (result),
    .used        (entries_used),
    .strobe      (result_strobe),
    .status      (status)
  );

  // Ring of cells; each takes its upper neighbor, the last takes the tail.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_last
      mft_cell u_cell (.clk(clk), .shift(shift), .din(tail), .q(ring[i]));
    end else begin : g_mid
      mft_cell u_cell (.clk(clk), .shift(shift), .din(ring[i+1]), .q(ring[i]));
    end
  end

  assign busy        = status.busy;
  assign entry_index = result.index;
  assign entry_mac   = result.mac;
  assign entry_count = result.count;
  assign was_new     = result.was_new;
  assign table_full  = result.full;
  assign entry_valid = result.valid;

  // Checks on the scan sequencing and the table bookkeeping.
  `MFT_ASSERT_NEXT(a_accept_starts_scan, clk, rst, start && !busy, busy)
  `MFT_ASSERT_SAME(a_strobe_not_busy, clk, rst, result_strobe, !busy)
  `MFT_ASSERT_SAME(a_new_is_valid, clk, rst, result_strobe && was_new,
                   entry_valid && !table_full)
  `MFT_ASSERT_SAME(a_full_at_depth, clk, rst, result_strobe && table_full,
                   status.fill == FILL_W'(TABLE_DEPTH))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the MAC address frequency table: directed and random requests, each result checked
// against its typed script row or an in-bench table predictor. Depends on mft_pkg.
module testbench;

  import mft_pkg::*;

  localparam int          DIRECTED_ROWS = 19;
  localparam int          RANDOM_ITEMS  = 1330;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam logic [63:0] COUNT_MAX     = (COUNT_WIDTH >= 64) ? '1 :
                                          ((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [47:0] ALL_ONES_MAC  = 48'hFFFF_FFFF_FFFF;

  // One result as it appears on the result ports.
  typedef struct packed {
    logic [OUT_IDX_W-1:0]  index;
    logic [MAC_W-1:0]      mac;
    logic [OUT_CNT_W-1:0]  count;
    logic                  was_new;
    logic                  full;
    logic                  valid;
    logic [OUT_FILL_W-1:0] used;
  } entry_result_t;

  // One row of the directed script; typed rows carry their own expectation.
  typedef struct packed {
    logic            op;
    logic [MAC_W-1:0] mac;
    logic [5:0]      idx;
    logic            typed;
    entry_result_t   res;
  } script_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  operation;
  logic [MAC_W-1:0]      mac_address;
  logic [OUT_IDX_W-1:0]  read_index;
  logic                  result_strobe;
  logic [OUT_IDX_W-1:0]  entry_index;
  logic [MAC_W-1:0]      entry_mac;
  logic [OUT_CNT_W-1:0]  entry_count;
  logic                  was_new;
  logic                  table_full;
  logic                  entry_valid;
  logic [OUT_FILL_W-1:0] entries_used;

  // Shadow copy of the table and the results still owed by the block.
  logic [MAC_W-1:0] known_mac [TABLE_DEPTH];
  logic [63:0]      known_count [TABLE_DEPTH];
  int               known_fill;
  entry_result_t    pending_results [$];
  entry_result_t    oldest_result;
  int               mismatch_count;
  int               cycle_count;

  mac_address_frequency_table_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .mac_address  (mac_address),
    .read_index   (read_index),
    .result_strobe(result_strobe),
    .entry_index  (entry_index),
    .entry_mac    (entry_mac),
    .entry_count  (entry_count),
    .was_new      (was_new),
    .table_full   (table_full),
    .entry_valid  (entry_valid),
    .entries_used (entries_used)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the result it yields.
  function automatic entry_result_t apply_table_request(input logic op,
                                                        input logic [MAC_W-1:0] mac,
                                                        input logic [5:0] idx);
    entry_result_t r;
    int slot;
    int i;
    r = '0;
    slot = -1;
    if (op == OP_READ) begin
      r.index = idx;
      if (int'(idx) < known_fill) slot = int'(idx);
    end else begin
      for (i = 0; i < known_fill; i++) begin
        if (slot < 0 && known_mac[i] == mac) slot = i;
      end
      if (slot >= 0) begin
        if (known_count[slot] != COUNT_MAX) known_count[slot] = known_count[slot] + 64'd1;
      end else if (known_fill < TABLE_DEPTH) begin
        slot = known_fill;
        known_mac[slot] = mac;
        known_count[slot] = 64'd1;
        known_fill++;
        r.was_new = 1'b1;
      end else begin
        // No room left: the address is dropped and echoed back.
        r.mac = mac;
        r.full = 1'b1;
      end
    end
    if (slot >= 0) begin
      r.index = OUT_IDX_W'(slot);
      r.mac = known_mac[slot];
      r.count = (known_count[slot] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF :
                known_count[slot][OUT_CNT_W-1:0];
      r.valid = 1'b1;
    end
    r.used = OUT_FILL_W'(known_fill);
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly short gaps, some around the busy window, a few well past it.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(40, 75);
    return $urandom_range(76, 160);
  endfunction

  // Holds a request on the inputs until it is taken, then books its result.
  task automatic issue_request(input logic op, input logic [MAC_W-1:0] mac,
                               input logic [5:0] idx, input logic typed,
                               input entry_result_t typed_res);
    entry_result_t predicted;
    start       <= 1'b1;
    operation   <= op;
    mac_address <= mac;
    read_index  <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = apply_table_request(op, mac, idx);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Lowers start for a number of cycles; a negative count waits for all results.
  task automatic pause_sender(input int cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      if (cycles < 0) begin
        while (pending_results.size() != 0) @(posedge clk);
      end else begin
        repeat (cycles) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] expected,
                             input logic [63:0] actual);
    if (actual !== expected) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
    end
  endtask

  // Each strobed result is matched against the oldest request still open.
  always @(posedge clk) begin
    if (rst === 1'b0 && result_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request open, expected none, actual index %0h",
                 $time, entry_index);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("entry_index", 64'(oldest_result.index), 64'(entry_index));
        check_field("entry_mac", 64'(oldest_result.mac), 64'(entry_mac));
        check_field("entry_count", 64'(oldest_result.count), 64'(entry_count));
        check_field("was_new", 64'(oldest_result.was_new), 64'(was_new));
        check_field("table_full", 64'(oldest_result.full), 64'(table_full));
        check_field("entry_valid", 64'(oldest_result.valid), 64'(entry_valid));
        check_field("entries_used", 64'(oldest_result.used), 64'(entries_used));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    script_row_t  script [DIRECTED_ROWS];
    int           n;
    int           pick;
    int           gap;
    logic         op;
    logic [MAC_W-1:0] mac;
    logic [5:0]   idx;

    rst            = 1'b1;
    start          = 1'b0;
    operation      = OP_COUNT;
    mac_address    = '0;
    read_index     = '0;
    known_fill     = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    // Empty-table reads, both address extremes, hits, reads on and past the fill.
    script = '{
      '{OP_READ,  48'h0,            6'd0,  1'b1, '{6'd0,  48'h0,        32'd0, 1'b0, 1'b0, 1'b0, 7'd0}},
      '{OP_READ,  48'h0,            6'd63, 1'b1, '{6'd63, 48'h0,        32'd0, 1'b0, 1'b0, 1'b0, 7'd0}},
      '{OP_COUNT, 48'h0,            6'd0,  1'b1, '{6'd0,  48'h0,        32'd1, 1'b1, 1'b0, 1'b1, 7'd1}},
      '{OP_COUNT, ALL_ONES_MAC,     6'd63, 1'b1, '{6'd1,  ALL_ONES_MAC, 32'd1, 1'b1, 1'b0, 1'b1, 7'd2}},
      '{OP_COUNT, 48'h0,            6'd0,  1'b1, '{6'd0,  48'h0,        32'd2, 1'b0, 1'b0, 1'b1, 7'd2}},
      '{OP_COUNT, ALL_ONES_MAC,     6'd0,  1'b1, '{6'd1,  ALL_ONES_MAC, 32'd2, 1'b0, 1'b0, 1'b1, 7'd2}},
      '{OP_READ,  ALL_ONES_MAC,     6'd0,  1'b1, '{6'd0,  48'h0,        32'd2, 1'b0, 1'b0, 1'b1, 7'd2}},
      '{OP_READ,  48'h0,            6'd1,  1'b1, '{6'd1,  ALL_ONES_MAC, 32'd2, 1'b0, 1'b0, 1'b1, 7'd2}},
      '{OP_READ,  48'h0,            6'd2,  1'b1, '{6'd2,  48'h0,        32'd0, 1'b0, 1'b0, 1'b0, 7'd2}},
      '{OP_COUNT, 48'h0000_0000_0001, 6'd0, 1'b0, '0},
      '{OP_COUNT, 48'h8000_0000_0000, 6'd0, 1'b0, '0},
      '{OP_COUNT, 48'h7FFF_FFFF_FFFF, 6'd0, 1'b0, '0},
      '{OP_COUNT, 48'hAAAA_AAAA_AAAA, 6'd0, 1'b0, '0},
      '{OP_COUNT, 48'h5555_5555_5555, 6'd0, 1'b0, '0},
      '{OP_COUNT, 48'hFFFF_FFFF_FFFE, 6'd0, 1'b0, '0},
      '{OP_READ,  48'h0,            6'd63, 1'b1, '{6'd63, 48'h0,        32'd0, 1'b0, 1'b0, 1'b0, 7'd8}},
      '{OP_COUNT, 48'h8000_0000_0000, 6'd0, 1'b0, '0},
      '{OP_READ,  48'h0,            6'd7,  1'b0, '0},
      '{OP_READ,  48'h0,            6'd8,  1'b1, '{6'd8,  48'h0,        32'd0, 1'b0, 1'b0, 1'b0, 7'd8}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      issue_request(script[n].op, script[n].mac, script[n].idx, script[n].typed, script[n].res);
      pause_sender(sender_gap());
    end
    pause_sender(-1);

    // Random part: hits on stored addresses, one-bit near misses, fresh
    // addresses that fill the table and then overflow it, and reads.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      op   = OP_COUNT;
      idx  = 6'($urandom_range(0, 63));
      mac  = random_mac();
      if (pick < 35) begin
        op = OP_READ;
        if (known_fill > 0 && $urandom_range(0, 9) < 7) begin
          idx = 6'($urandom_range(0, known_fill - 1));
        end
      end else if (pick < 75 && known_fill > 0) begin
        mac = known_mac[$urandom_range(0, known_fill - 1)];
      end else if (pick < 87 && known_fill > 0) begin
        mac = known_mac[$urandom_range(0, known_fill - 1)] ^
              (48'd1 << $urandom_range(0, MAC_W - 1));
      end
      issue_request(op, mac, idx, 1'b0, '0);

      // Every third block of a hundred runs back to back.
      gap = ((n / 100) % 3 == 1) ? 0 : sender_gap();
      if (n % 250 == 249) gap = -1;
      pause_sender(gap);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
